FILE: rtl/slrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slrc_pkg: shared types and constants
// Command text table, cell count and the link struct that runs along the cell row.
// ----------------------------------------------------------------------------
package slrc_pkg;

    localparam int unsigned NUM_CMD = 8;
    // one cell per line position that a command can reach, plus its terminator
    localparam int unsigned CELLS   = 8;

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef logic [NUM_CMD-1:0] t_cmd_vec;

    // what one cell hands to its right neighbor
    typedef struct packed {
        logic     ptr;   // write pointer token sits here
        t_cmd_vec ok;    // command still matches through this position
    } t_link;

    localparam logic [3:0] CMD_LEN [NUM_CMD] = '{
        4'd6, 4'd7, 4'd6, 4'd7, 4'd6, 4'd7, 4'd6, 4'd7
    };

    localparam logic [7:0] CMD_CHAR [NUM_CMD][CELLS] = '{
        '{"I", "N", "1", "_", "O", "N", 8'h00, 8'h00},
        '{"I", "N", "1", "_", "O", "F", "F",   8'h00},
        '{"I", "N", "2", "_", "O", "N", 8'h00, 8'h00},
        '{"I", "N", "2", "_", "O", "F", "F",   8'h00},
        '{"I", "N", "3", "_", "O", "N", 8'h00, 8'h00},
        '{"I", "N", "3", "_", "O", "F", "F",   8'h00},
        '{"I", "N", "4", "_", "O", "N", 8'h00, 8'h00},
        '{"I", "N", "4", "_", "O", "F", "F",   8'h00}
    };

endpackage

`default_nettype wire

FILE: rtl/slrc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slrc_cell: one line position
// Holds one received byte, passes the write token right and extends the
// per-command match from its left neighbor.
// ----------------------------------------------------------------------------
module slrc_cell #(
    parameter int unsigned POS  = 0,
    parameter bit          KEEP = 1'b0   // token stays here once it arrives
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,   // ordinary byte accepted
    input  wire logic          i_clear,  // newline accepted
    input  wire logic [7:0]    i_byte,
    input  wire slrc_pkg::t_link i_link,
    output slrc_pkg::t_link    o_link
);
    import slrc_pkg::*;

    logic       r_ptr;
    logic       r_done;   // written during the current line
    logic [7:0] r_byte;
    logic       n_ptr;
    logic       n_done;

    always_comb begin
        n_ptr  = r_ptr;
        n_done = r_done;
        if (i_clear) begin
            n_ptr  = (POS == 0);
            n_done = 1'b0;
        end else if (i_load) begin
            n_ptr = i_link.ptr || (r_ptr && KEEP);
            if (r_ptr && !KEEP) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= (POS == 0);
            r_done <= 1'b0;
        end else begin
            r_ptr  <= n_ptr;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && r_ptr) begin
            r_byte <= i_byte;
        end
    end

    always_comb begin
        o_link.ptr = r_ptr;
        for (int c = 0; c < NUM_CMD; c++) begin
            if (POS < int'(CMD_LEN[c])) begin
                o_link.ok[c] = i_link.ok[c] && r_done && (r_byte == CMD_CHAR[c][POS]);
            end else if (POS == int'(CMD_LEN[c])) begin
                // line ends here: token here, or a zero byte stored this line
                o_link.ok[c] = i_link.ok[c] && (r_ptr || (r_done && (r_byte == 8'h00)));
            end else begin
                o_link.ok[c] = i_link.ok[c];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/serial_line_relay_command_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_relay_command_decoder: ascii relay command decoder
// Collects received bytes into a line and decodes IN1_ON .. IN4_OFF on newline.
// ----------------------------------------------------------------------------
// a newline byte yields its result in the output register in the cycle
// after it is accepted; ordinary bytes yield no result
// throughput: one byte per cycle, stalled while an undrained result is held
// reset: synchronous active low; relays off (levels all ones), line empty,
//   output register empty; no clearing pass, the line store needs none
module serial_line_relay_command_decoder #(
    parameter int unsigned BUFFER_CHARS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // slave side: one received byte per request
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] rx_byte
    // master side: one result per newline
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata     // [3:0] command_code, [7:4] relay_levels
);
    import slrc_pkg::*;

    // the line store index saturates at BUFFER_CHARS-1; only when that slot
    // falls inside the cell row does the last cell keep the write token
    localparam bit SAT_IN_ROW = (BUFFER_CHARS <= CELLS);

    logic       w_accept;
    logic       w_newline;
    logic       w_load;
    logic       w_clear;
    t_link      w_link [CELLS+1];
    t_cmd_vec   w_match;

    logic [3:0] n_code;
    logic [3:0] n_relay;
    logic [3:0] r_relay;
    logic [3:0] r_code;
    logic [3:0] r_levels;
    logic       r_valid;

    // the output register frees up the same cycle it is drained
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_newline     = (s_axis_tdata == NEWLINE);
    assign w_load        = w_accept && !w_newline;
    assign w_clear       = w_accept && w_newline;

    // head of the row: every command starts as a candidate, no token enters
    assign w_link[0].ptr = 1'b0;
    assign w_link[0].ok  = '1;

    // row of position cells, token and match flow left to right
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        slrc_cell #(
            .POS  (g),
            .KEEP ((g == CELLS - 1) && SAT_IN_ROW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_clear (w_clear),
            .i_byte  (s_axis_tdata),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    assign w_match = w_link[CELLS].ok;

    // commands are distinct, so at most one match; even index means on (low)
    always_comb begin
        n_code  = '0;
        n_relay = r_relay;
        for (int c = 0; c < NUM_CMD; c++) begin
            if (w_match[c]) begin
                n_code       = 4'(c + 1);
                n_relay[c/2] = 1'(c % 2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay <= '1;
            r_valid <= 1'b0;
        end else begin
            if (w_clear) begin
                r_relay <= n_relay;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_code   <= n_code;
            r_levels <= n_relay;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_levels, r_code};

endmodule

`default_nettype wire
